// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker in clsu_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle as its condition.
`define CLSU_ASSERT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Property holds in the cycle after its condition.
`define CLSU_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

// ===== rtl/clsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package clsu_pkg;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_STOP = 2'd3;

    localparam logic [1:0] PK_NONE  = 2'd0;
    localparam logic [1:0] PK_HIGH  = 2'd1;
    localparam logic [1:0] PK_QUOTE = 2'd2;
    localparam logic [1:0] PK_BSLASH = 2'd3;

    localparam logic [1:0] REG_MAX_ARGS  = 2'd0;
    localparam logic [1:0] REG_BYTE_CAP  = 2'd1;
    localparam logic [1:0] REG_MAX_STEPS = 2'd2;

    localparam int BUNDLE_BYTES = 8;

    // All results caused by one code unit: bytes, then an argument end, then a tail mark.
    typedef struct packed {
        logic [3:0]                     total;
        logic [2:0]                     nbytes;
        logic [BUNDLE_BYTES-1:0][7:0]   bytes;
        logic [BUNDLE_BYTES-1:0][14:0]  reps;
        logic                           end_valid;
        logic [17:0]                    end_offset;
        logic [17:0]                    end_length;
        logic [15:0]                    end_number;
        logic                           tail_valid;
        logic [1:0]                     tail_kind;
        logic [15:0]                    tail_number;
    } bundle_t;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] b;
    } utf8_t;

endpackage
`default_nettype wire

// ===== rtl/clsu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module clsu_front import clsu_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [17:0] cfg_data,
    input  wire logic        accept,
    input  wire logic [15:0] code_unit,
    output bundle_t          bundle,
    output logic             bundle_push
);

    logic [15:0] max_args_reg;
    logic [17:0] byte_cap_reg;
    logic [14:0] max_steps_reg;

    logic        quoted_reg, quoted_next;
    logic        arg_open_reg, arg_open_next;
    logic [1:0]  pend_reg, pend_next;
    logic [9:0]  high_reg, high_next;
    logic [14:0] run_reg, run_next;
    logic [14:0] steps_reg, steps_next;
    logic [17:0] offset_reg, offset_next;
    logic [17:0] start_reg, start_next;
    logic [15:0] count_reg, count_next;
    logic        halted_reg, halted_next;

    bundle_t     b;
    logic        used;
    logic        emit_a, emit_b;
    logic [20:0] cp_a, cp_b;
    utf8_t       enc;
    logic [14:0] run;
    logic [14:0] pairs;
    logic        opened;

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r = '0;
        if (cp <= 21'h7F) begin
            r.len  = 3'd1;
            r.b[0] = cp[7:0];
        end
        else if (cp <= 21'h7FF) begin
            r.len  = 3'd2;
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
        end
        else if (cp <= 21'hFFFF) begin
            r.len  = 3'd3;
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
        end
        else begin
            r.len  = 3'd4;
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    always_comb
    begin
        quoted_next   = quoted_reg;
        arg_open_next = arg_open_reg;
        pend_next     = pend_reg;
        high_next     = high_reg;
        run_next      = run_reg;
        steps_next    = steps_reg;
        offset_next   = offset_reg;
        start_next    = start_reg;
        count_next    = count_reg;
        halted_next   = halted_reg;
        b      = '0;
        used   = 1'b0;
        emit_a = 1'b0;
        emit_b = 1'b0;
        cp_a   = '0;
        cp_b   = '0;
        enc    = '0;
        run    = '0;
        pairs  = '0;
        opened = 1'b1;

        if (!halted_reg) begin
            case (pend_reg)
                PK_HIGH:
                begin
                    pend_next = PK_NONE;
                    emit_a    = 1'b1;
                    if (code_unit inside {[16'hDC00:16'hDFFF]}) begin
                        cp_a = 21'h10000 + {1'b0, high_reg, 10'd0} + {11'd0, code_unit[9:0]};
                        used = 1'b1;
                    end
                    else begin
                        cp_a = 21'hFFFD;
                    end
                end
                PK_QUOTE:
                begin
                    pend_next = PK_NONE;
                    if (code_unit == 16'h0022) begin
                        used = 1'b1;
                        if (offset_next >= byte_cap_reg) begin
                            halted_next = 1'b1;
                        end
                        else begin
                            b.bytes[b.nbytes] = 8'h22;
                            b.reps[b.nbytes]  = 15'd1;
                            b.nbytes          = b.nbytes + 3'd1;
                            offset_next       = offset_next + 18'd1;
                        end
                    end
                    else begin
                        quoted_next = 1'b0;
                    end
                end
                PK_BSLASH:
                begin
                    if (code_unit == 16'h005C) begin
                        used = 1'b1;
                        if (run_reg == 15'h7FFF) halted_next = 1'b1;
                        else run_next = run_reg + 15'd1;
                    end
                    else begin
                        pend_next = PK_NONE;
                        run       = run_reg;
                        run_next  = '0;
                        if (code_unit == 16'h0022) begin
                            used  = 1'b1;
                            pairs = run >> 1;
                            if ({1'b0, offset_next} + {4'd0, pairs} > {1'b0, byte_cap_reg}) begin
                                halted_next = 1'b1;
                            end
                            else begin
                                if (pairs != '0) begin
                                    b.bytes[b.nbytes] = 8'h5C;
                                    b.reps[b.nbytes]  = pairs;
                                    b.nbytes          = b.nbytes + 3'd1;
                                    offset_next       = offset_next + {3'd0, pairs};
                                end
                                if (run[0]) begin
                                    if (offset_next >= byte_cap_reg) begin
                                        halted_next = 1'b1;
                                    end
                                    else begin
                                        b.bytes[b.nbytes] = 8'h22;
                                        b.reps[b.nbytes]  = 15'd1;
                                        b.nbytes          = b.nbytes + 3'd1;
                                        offset_next       = offset_next + 18'd1;
                                    end
                                end
                                else begin
                                    quoted_next = ~quoted_next;
                                end
                            end
                        end
                        else begin
                            if ({1'b0, offset_next} + {4'd0, run} > {1'b0, byte_cap_reg}) begin
                                halted_next = 1'b1;
                            end
                            else if (run != '0) begin
                                b.bytes[b.nbytes] = 8'h5C;
                                b.reps[b.nbytes]  = run;
                                b.nbytes          = b.nbytes + 3'd1;
                                offset_next       = offset_next + {3'd0, run};
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (emit_a) begin
                enc = utf8_encode(cp_a);
                if ({1'b0, offset_next} + {16'd0, enc.len} > {1'b0, byte_cap_reg}) begin
                    halted_next = 1'b1;
                end
                else begin
                    for (int i = 0; i < 4; i++) begin
                        if (i < int'(enc.len)) begin
                            b.bytes[b.nbytes] = enc.b[i];
                            b.reps[b.nbytes]  = 15'd1;
                            b.nbytes          = b.nbytes + 3'd1;
                        end
                    end
                    offset_next = offset_next + {15'd0, enc.len};
                end
            end

            if (!halted_next && !used) begin
                if (code_unit == 16'd0) begin
                    if (arg_open_next) begin
                        if (count_next >= max_args_reg) begin
                            halted_next = 1'b1;
                        end
                        else begin
                            b.end_valid   = 1'b1;
                            b.end_offset  = start_next;
                            b.end_length  = offset_next - start_next;
                            b.end_number  = count_next;
                            count_next    = count_next + 16'd1;
                            arg_open_next = 1'b0;
                        end
                    end
                    if (!halted_next) begin
                        b.tail_valid  = 1'b1;
                        b.tail_kind   = KIND_DONE;
                        b.tail_number = count_next;
                    end
                end
                else if (steps_next >= max_steps_reg) begin
                    halted_next = 1'b1;
                end
                else begin
                    steps_next = steps_next + 15'd1;
                    if (!quoted_next && (code_unit == 16'h0020 || code_unit == 16'h0009)) begin
                        if (arg_open_next) begin
                            if (count_next >= max_args_reg) begin
                                halted_next = 1'b1;
                            end
                            else begin
                                b.end_valid   = 1'b1;
                                b.end_offset  = start_next;
                                b.end_length  = offset_next - start_next;
                                b.end_number  = count_next;
                                count_next    = count_next + 16'd1;
                                arg_open_next = 1'b0;
                            end
                        end
                    end
                    else begin
                        if (!arg_open_next) begin
                            if (count_next >= max_args_reg || offset_next >= byte_cap_reg) begin
                                halted_next = 1'b1;
                                opened      = 1'b0;
                            end
                            else begin
                                arg_open_next = 1'b1;
                                start_next    = offset_next;
                            end
                        end
                        if (opened) begin
                            if (code_unit == 16'h0022) begin
                                if (quoted_next) pend_next = PK_QUOTE;
                                else quoted_next = 1'b1;
                            end
                            else if (code_unit == 16'h005C) begin
                                pend_next = PK_BSLASH;
                                run_next  = 15'd1;
                            end
                            else if (code_unit inside {[16'hD800:16'hDBFF]}) begin
                                pend_next = PK_HIGH;
                                high_next = code_unit[9:0];
                            end
                            else if (code_unit inside {[16'hDC00:16'hDFFF]}) begin
                                emit_b = 1'b1;
                                cp_b   = 21'hFFFD;
                            end
                            else begin
                                emit_b = 1'b1;
                                cp_b   = {5'd0, code_unit};
                            end
                        end
                    end
                end
            end

            if (emit_b) begin
                enc = utf8_encode(cp_b);
                if ({1'b0, offset_next} + {16'd0, enc.len} > {1'b0, byte_cap_reg}) begin
                    halted_next = 1'b1;
                end
                else begin
                    for (int i = 0; i < 4; i++) begin
                        if (i < int'(enc.len)) begin
                            b.bytes[b.nbytes] = enc.b[i];
                            b.reps[b.nbytes]  = 15'd1;
                            b.nbytes          = b.nbytes + 3'd1;
                        end
                    end
                    offset_next = offset_next + {15'd0, enc.len};
                end
            end

            if (halted_next) begin
                b.tail_valid  = 1'b1;
                b.tail_kind   = KIND_STOP;
                b.tail_number = count_next;
            end
        end

        b.total = {1'b0, b.nbytes} + {3'd0, b.end_valid} + {3'd0, b.tail_valid};

        if (code_unit == 16'd0) begin
            quoted_next   = 1'b0;
            arg_open_next = 1'b0;
            pend_next     = PK_NONE;
            high_next     = '0;
            run_next      = '0;
            steps_next    = '0;
            offset_next   = '0;
            start_next    = '0;
            count_next    = '0;
            halted_next   = 1'b0;
        end
    end

    assign bundle      = b;
    assign bundle_push = accept && (b.total != 4'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_args_reg  <= 16'd1024;
            byte_cap_reg  <= 18'd98304;
            max_steps_reg <= 15'd32767;
            quoted_reg    <= 1'b0;
            arg_open_reg  <= 1'b0;
            pend_reg      <= PK_NONE;
            high_reg      <= '0;
            run_reg       <= '0;
            steps_reg     <= '0;
            offset_reg    <= '0;
            start_reg     <= '0;
            count_reg     <= '0;
            halted_reg    <= 1'b0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MAX_ARGS:  max_args_reg  <= cfg_data[15:0];
                    REG_BYTE_CAP:  byte_cap_reg  <= cfg_data;
                    REG_MAX_STEPS: max_steps_reg <= cfg_data[14:0];
                    default:
                    begin
                    end
                endcase
            end
            if (accept) begin
                quoted_reg   <= quoted_next;
                arg_open_reg <= arg_open_next;
                pend_reg     <= pend_next;
                high_reg     <= high_next;
                run_reg      <= run_next;
                steps_reg    <= steps_next;
                offset_reg   <= offset_next;
                start_reg    <= start_next;
                count_reg    <= count_next;
                halted_reg   <= halted_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/clsu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module clsu_queue import clsu_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  bundle_t   wr_data,
    output logic      full,
    input  wire logic rd_en,
    output bundle_t   rd_data,
    output logic      not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t         mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (wr_en) wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en) rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + CW'(wr_en) - CW'(rd_en);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/clsu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module clsu_back import clsu_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  bundle_t           head,
    input  wire logic         head_valid,
    output logic              head_pop,
    output logic              empty,
    input  wire logic         pop,
    output logic [1:0]        kind,
    output logic [7:0]        out_byte,
    output logic [14:0]       repeat_count,
    output logic [17:0]       arg_offset,
    output logic [17:0]       arg_length,
    output logic [15:0]       arg_number,
    output logic              last
);

    logic [3:0]  ptr_reg;
    logic        valid_reg;
    logic        load;
    logic        is_last;
    logic [1:0]  kind_next;
    logic [7:0]  byte_next;
    logic [14:0] rep_next;
    logic [17:0] off_next, len_next;
    logic [15:0] num_next;

    always_comb
    begin
        kind_next = KIND_DATA;
        byte_next = '0;
        rep_next  = '0;
        off_next  = '0;
        len_next  = '0;
        num_next  = '0;
        if (ptr_reg < {1'b0, head.nbytes}) begin
            byte_next = head.bytes[ptr_reg[2:0]];
            rep_next  = head.reps[ptr_reg[2:0]];
        end
        else if (head.end_valid && ptr_reg == {1'b0, head.nbytes}) begin
            kind_next = KIND_END;
            off_next  = head.end_offset;
            len_next  = head.end_length;
            num_next  = head.end_number;
        end
        else begin
            kind_next = head.tail_kind;
            num_next  = head.tail_number;
        end
    end

    assign is_last  = (ptr_reg == head.total - 4'd1);
    assign load     = head_valid && (!valid_reg || pop);
    assign head_pop = load && is_last;
    assign empty    = !valid_reg;

    always_ff @(posedge clk)
    begin
        if (load) begin
            kind         <= kind_next;
            out_byte     <= byte_next;
            repeat_count <= rep_next;
            arg_offset   <= off_next;
            arg_length   <= len_next;
            arg_number   <= num_next;
            last         <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ptr_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else begin
            if (load) begin
                ptr_reg   <= is_last ? 4'd0 : ptr_reg + 4'd1;
                valid_reg <= 1'b1;
            end
            else if (pop) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/command_line_splitter_utf8.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A unit's results are registered in the bundle queue, then in the back end's outputs.
// Throughput: one code unit per cycle while full is low and each unit gives at most one
// result; the back end delivers one result per cycle while pop is held high.
// The bundle queue (QUEUE_DEPTH entries) lets the front keep taking units meanwhile.
// Reset: asynchronous, active low; clears parse state and queues, registers to defaults.
module command_line_splitter_utf8 import clsu_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [17:0] cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [15:0] code_unit,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       kind,
    output logic [7:0]       out_byte,
    output logic [14:0]      repeat_count,
    output logic [17:0]      arg_offset,
    output logic [17:0]      arg_length,
    output logic [15:0]      arg_number,
    output logic             last
);

    bundle_t fe_bundle, hd_bundle;
    logic    fe_push, q_full, q_valid, q_pop;

    assign full = q_full;

    clsu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (push && !q_full),
        .code_unit   (code_unit),
        .bundle      (fe_bundle),
        .bundle_push (fe_push)
    );

    clsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (fe_push),
        .wr_data   (fe_bundle),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_data   (hd_bundle),
        .not_empty (q_valid)
    );

    clsu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (hd_bundle),
        .head_valid   (q_valid),
        .head_pop     (q_pop),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .out_byte     (out_byte),
        .repeat_count (repeat_count),
        .arg_offset   (arg_offset),
        .arg_length   (arg_length),
        .arg_number   (arg_number),
        .last         (last)
    );

endmodule
`default_nettype wire

// ===== rtl/clsu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module clsu_checker import clsu_pkg::*; (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [1:0]  kind,
    input wire logic [7:0]  out_byte,
    input wire logic [14:0] repeat_count,
    input wire logic [15:0] arg_number,
    input wire logic        last
);

    `CLSU_ASSERT(a_data_rep, !empty && kind == KIND_DATA, repeat_count != '0)
    `CLSU_ASSERT(a_mark_clean, !empty && kind != KIND_DATA, out_byte == '0 && repeat_count == '0)
    `CLSU_ASSERT(a_tail_last, !empty && (kind == KIND_DONE || kind == KIND_STOP), last)
    `CLSU_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(kind) && $stable(arg_number))

endmodule

bind command_line_splitter_utf8 clsu_checker u_clsu_checker (.*);
`default_nettype wire
